// ----- rtl/core/pgat_pkg.sv -----
// Shared types and constants for the periodic GPIO action timers.
package pgat_pkg;

    // Fixed register and field layout.
    localparam int SETUP_W    = 38;
    localparam int TIME_W     = 32;
    localparam int SECS_W     = 17;
    localparam int DUR_W      = 16;
    localparam int SLOTS      = 4;
    localparam int CH_IDX_W   = 2;
    localparam int MASK_W     = 4;
    localparam logic [9:0] MS_PER_SEC = 10'd1000;

    // Input command codes.
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_RELOAD = 1'b1;

    // Channel action codes.
    typedef enum logic [2:0] {
        ACT_HIGH       = 3'd0,
        ACT_LOW        = 3'd1,
        ACT_TOGGLE     = 3'd2,
        ACT_PULSE_HIGH = 3'd3,
        ACT_PULSE_LOW  = 3'd4
    } action_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } seq_state_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic                accept;
        logic                step;
        logic                load_out;
        logic [CH_IDX_W-1:0] chan;
    } seq_ctl_t;

    // Stored state of one channel.
    typedef struct packed {
        logic [TIME_W-1:0] last_fire;
        logic [TIME_W-1:0] deadline;
        logic              running;
        logic              out_en;
        logic              level;
    } chan_state_t;

    // Result of one channel evaluation.
    typedef struct packed {
        chan_state_t nxt;
        logic        fired;
        logic        ended;
    } chan_upd_t;

endpackage

// ----- rtl/core/periodic_gpio_action_timers_top.sv -----
// Top level of the periodic GPIO action timers: channel state, sequencer and output register.
//
//  Channel  Signals                                   Direction  Handshake
//  input    cmd, now_ms                               in         in_valid / in_stall
//  output   pin_levels, pin_enables, fired_mask,      out        out_valid / out_stall
//           pulse_end_mask
//  config   cfg_index, cfg_data                       in         cfg_valid / cfg_ready
//
// Each transaction walks the channels one by one through the single shared evaluation
// unit, then loads the result register. The input is stalled from acceptance until the
// result register is loaded; a stalled result holds the block in its final state. Reset
// is asynchronous and clears all channel state and setup registers. Configuration writes
// are always ready.
module periodic_gpio_action_timers_top
    import pgat_pkg::*;
#(
    parameter int CHANNELS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  logic [TIME_W-1:0]   now_ms,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [MASK_W-1:0]   pin_levels,
    output logic [MASK_W-1:0]   pin_enables,
    output logic [MASK_W-1:0]   fired_mask,
    output logic [MASK_W-1:0]   pulse_end_mask,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CH_IDX_W-1:0] cfg_index,
    input  logic [SETUP_W-1:0]  cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [SETUP_W-1:0]  setup_reg [CHANNELS];
    chan_state_t         chan_reg  [CHANNELS];
    logic                cmd_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [MASK_W-1:0]   fired_acc_reg, ended_acc_reg;
    logic                out_valid_reg;
    logic [MASK_W-1:0]   levels_reg, enables_reg, fired_reg, ended_reg;
    logic [MASK_W-1:0]   levels_next, enables_next;
    logic                busy;
    logic                out_free;
    seq_ctl_t            ctl;
    logic [CH_W-1:0]     idx;
    chan_upd_t           upd;

    assign idx       = ctl.chan[CH_W-1:0];
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = busy;
    assign cfg_ready = 1'b1;

    // Channel sequencer.
    pgat_seq #(
        .CHANNELS (CHANNELS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .busy     (busy),
        .ctl      (ctl)
    );

    // Shared per-channel evaluation unit.
    pgat_chan_unit u_unit (
        .cmd    (cmd_reg),
        .now_ms (now_reg),
        .setup  (setup_reg[idx]),
        .cur    (chan_reg[idx]),
        .upd    (upd)
    );

    // Setup registers; writes to absent channels are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                setup_reg[i] <= '0;
            end
        end
        else if (cfg_valid && ({30'd0, cfg_index} < 32'(CHANNELS)))
        begin
            setup_reg[cfg_index[CH_W-1:0]] <= cfg_data;
        end
    end

    // Captured transaction and per-channel state write-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg       <= CMD_TICK;
            now_reg       <= '0;
            fired_acc_reg <= '0;
            ended_acc_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                chan_reg[i] <= '0;
            end
        end
        else
        begin
            if (ctl.accept)
            begin
                cmd_reg       <= cmd;
                now_reg       <= now_ms;
                fired_acc_reg <= '0;
                ended_acc_reg <= '0;
            end
            if (ctl.step)
            begin
                chan_reg[idx]                  <= upd.nxt;
                fired_acc_reg[ctl.chan]        <= upd.fired;
                ended_acc_reg[ctl.chan]        <= upd.ended;
            end
        end
    end

    // Pin level and enable vectors; absent channels read as zero.
    always_comb
    begin
        levels_next  = '0;
        enables_next = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            levels_next[i]  = chan_reg[i].level;
            enables_next[i] = chan_reg[i].out_en;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            levels_reg  <= levels_next;
            enables_reg <= enables_next;
            fired_reg   <= fired_acc_reg;
            ended_reg   <= ended_acc_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pin_levels     = levels_reg;
    assign pin_enables    = enables_reg;
    assign fired_mask     = fired_reg;
    assign pulse_end_mask = ended_reg;

endmodule

// ----- rtl/core/pgat_chan_unit.sv -----
// Shared evaluation unit: updates the state of one channel for one command.
module pgat_chan_unit
    import pgat_pkg::*;
(
    input  logic               cmd,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic [SETUP_W-1:0] setup,
    input  chan_state_t        cur,
    output chan_upd_t          upd
);

    logic              enable;
    logic [2:0]        action;
    logic              pol_invert;
    logic [SECS_W-1:0] secs;
    logic [DUR_W-1:0]  dur;
    logic [TIME_W-1:0] interval;
    logic [TIME_W-1:0] elapsed;
    logic              end_hit;
    logic              fire_hit;
    logic              run_mid;
    logic              lvl_mid;

    // Unpack the channel setup register.
    assign enable     = setup[0];
    assign action     = setup[3:1];
    assign pol_invert = setup[4];
    assign secs       = setup[21:5];
    assign dur        = setup[37:22];

    // Interval in milliseconds; a zero seconds count means one second.
    always_comb
    begin
        if (secs == '0)
        begin
            interval = TIME_W'(MS_PER_SEC);
        end
        else
        begin
            interval = TIME_W'(secs) * TIME_W'(MS_PER_SEC);
        end
    end

    // Pulse end test and wrapped time since the last firing.
    assign end_hit  = cur.running && (now_ms >= cur.deadline);
    assign elapsed  = now_ms - cur.last_fire;
    assign fire_hit = (elapsed >= interval);

    // Level and pulse flag after a possible pulse end.
    always_comb
    begin
        run_mid = cur.running;
        lvl_mid = cur.level;
        if (end_hit)
        begin
            run_mid = 1'b0;
            if (action == ACT_PULSE_HIGH)
            begin
                lvl_mid = pol_invert;
            end
            else if (action == ACT_PULSE_LOW)
            begin
                lvl_mid = ~pol_invert;
            end
        end
    end

    // New channel state for a reload or a tick.
    always_comb
    begin
        upd.nxt   = cur;
        upd.fired = 1'b0;
        upd.ended = 1'b0;
        if (cmd == CMD_RELOAD)
        begin
            upd.nxt.last_fire = now_ms;
            upd.nxt.running   = 1'b0;
            upd.nxt.out_en    = 1'b0;
        end
        else if (enable)
        begin
            upd.ended       = end_hit;
            upd.nxt.running = run_mid;
            upd.nxt.level   = lvl_mid;
            if (fire_hit)
            begin
                upd.fired         = 1'b1;
                upd.nxt.last_fire = now_ms;
                upd.nxt.out_en    = 1'b1;
                unique case (action)
                    ACT_HIGH:   upd.nxt.level = ~pol_invert;
                    ACT_LOW:    upd.nxt.level = pol_invert;
                    ACT_TOGGLE: upd.nxt.level = ~lvl_mid;
                    ACT_PULSE_HIGH, ACT_PULSE_LOW:
                    begin
                        if (!run_mid)
                        begin
                            upd.nxt.level    = (action == ACT_PULSE_HIGH) ^ pol_invert;
                            upd.nxt.running  = 1'b1;
                            upd.nxt.deadline = now_ms + TIME_W'(dur);
                        end
                    end
                    default:    upd.nxt.level = lvl_mid;
                endcase
            end
        end
    end

endmodule

// ----- rtl/core/pgat_seq.sv -----
// Sequencer that walks the channels through the shared unit once per item.
module pgat_seq
    import pgat_pkg::*;
#(
    parameter int CHANNELS = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     out_free,
    output logic     busy,
    output seq_ctl_t ctl
);

    seq_state_t          state_reg, state_next;
    logic [CH_IDX_W-1:0] chan_reg, chan_next;
    logic                last_chan;

    assign last_chan = (chan_reg == CH_IDX_W'(CHANNELS - 1));

    // State and channel counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            chan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
        end
    end

    // Next state logic.
    always_comb
    begin
        state_next = state_reg;
        chan_next  = chan_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                chan_next = '0;
                if (in_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_chan)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    chan_next = chan_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output decode.
    always_comb
    begin
        ctl.chan     = chan_reg;
        ctl.accept   = 1'b0;
        ctl.step     = 1'b0;
        ctl.load_out = 1'b0;
        busy         = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                ctl.accept = in_valid;
            end
            ST_RUN:
            begin
                ctl.step = 1'b1;
            end
            ST_DONE:
            begin
                ctl.load_out = out_free;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
